// ----- rtl/core/tgarle_pkg.sv -----
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the Targa run-length pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tgarle_pkg;

  // Configuration register indexes
  localparam logic CFG_RLE_ENABLE   = 1'b0;
  localparam logic CFG_PIXEL_FORMAT = 1'b1;

  // Reset values of the configuration registers
  localparam logic       RLE_ENABLE_RST = 1'b0;

  typedef enum logic [1:0] {
    FMT_GREY8  = 2'd0,
    FMT_RGB555 = 2'd1,
    FMT_BGR24  = 2'd2,
    FMT_BGRA32 = 2'd3
  } pix_fmt_e;

  localparam pix_fmt_e PIXEL_FORMAT_RST = FMT_BGR24;

  // Packet header fields
  localparam int unsigned HDR_REPEAT_BIT = 7;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] pixel_code;
    logic [7:0]  repeat_count;
  } pix_t;

endpackage : tgarle_pkg

`default_nettype wire

// ----- rtl/core/tgarle_byte_if.sv -----
// ----------------------------------------------------------------------------
// tgarle_byte_if
// Valid/ready channel carrying one pixel-data byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgarle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface : tgarle_byte_if

`default_nettype wire

// ----- rtl/core/tgarle_pix_if.sv -----
// ----------------------------------------------------------------------------
// tgarle_pix_if
// Valid/ready channel carrying one decoded pixel per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgarle_pix_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] pixel_code;
  logic [7:0]  repeat_count;

  modport source (output valid, output red, output green, output blue,
                  output pixel_code, output repeat_count, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input pixel_code, input repeat_count, output ready);
endinterface : tgarle_pix_if

`default_nettype wire

// ----- rtl/core/tgarle_decode.sv -----
// ----------------------------------------------------------------------------
// tgarle_decode
// Packet and pixel assembly state; decodes one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_decode
  import tgarle_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       rle_en_i,
  input  wire pix_fmt_e   fmt_i,
  output logic            res_valid_o,
  output pix_t            res_o
);

  logic        need_hdr_q, need_hdr_d;
  logic [7:0]  left_q, left_d;
  logic        rpt_q, rpt_d;
  logic [1:0]  pos_q, pos_d;
  logic [23:0] gath_q, gath_d;

  logic       is_hdr;
  logic       is_gather;
  logic       is_emit;
  logic [7:0] left_dec;
  logic [7:0] lo;

  assign is_hdr    = rle_en_i && need_hdr_q;
  assign is_gather = !is_hdr && (pos_q < fmt_i);
  assign is_emit   = !is_hdr && !is_gather;
  assign left_dec  = (left_q != 8'd0) ? left_q - 8'd1 : left_q;
  assign lo        = gath_q[7:0];

  always_comb begin
    need_hdr_d = need_hdr_q;
    left_d     = left_q;
    rpt_d      = rpt_q;
    pos_d      = pos_q;
    gath_d     = gath_q;
    res_o      = '0;
    res_o.repeat_count = 8'd1;

    case (fmt_i)
      FMT_GREY8: begin
        res_o.red        = byte_i;
        res_o.green      = byte_i;
        res_o.blue       = byte_i;
        res_o.pixel_code = {8'd0, byte_i};
      end
      FMT_RGB555: begin
        res_o.red        = {3'd0, byte_i[6:2]};
        res_o.green      = {3'd0, byte_i[1:0], lo[7:5]};
        res_o.blue       = {3'd0, lo[4:0]};
        res_o.pixel_code = {byte_i, lo};
      end
      FMT_BGR24: begin
        res_o.red   = byte_i;
        res_o.green = gath_q[15:8];
        res_o.blue  = gath_q[7:0];
      end
      FMT_BGRA32: begin
        res_o.red   = gath_q[23:16];
        res_o.green = gath_q[15:8];
        res_o.blue  = gath_q[7:0];
      end
      default: begin
        res_o.red = byte_i;
      end
    endcase

    if (is_hdr) begin
      rpt_d      = byte_i[HDR_REPEAT_BIT];
      left_d     = {1'b0, byte_i[6:0]} + 8'd1;
      need_hdr_d = 1'b0;
    end else if (is_gather) begin
      case (pos_q)
        2'd0:    gath_d[7:0]   = byte_i;
        2'd1:    gath_d[15:8]  = byte_i;
        2'd2:    gath_d[23:16] = byte_i;
        default: gath_d        = gath_q;
      endcase
      pos_d = pos_q + 2'd1;
    end else begin
      pos_d = 2'd0;
      if (rle_en_i) begin
        if (rpt_q) begin
          res_o.repeat_count = (left_q != 8'd0) ? left_q : 8'd1;
          left_d     = 8'd0;
          need_hdr_d = 1'b1;
        end else begin
          left_d = left_dec;
          if (left_dec == 8'd0) begin
            need_hdr_d = 1'b1;
          end
        end
      end
    end
  end

  assign res_valid_o = is_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_hdr_q <= 1'b1;
      left_q     <= 8'd0;
      rpt_q      <= 1'b0;
      pos_q      <= 2'd0;
      gath_q     <= 24'd0;
    end else if (step_i) begin
      need_hdr_q <= need_hdr_d;
      left_q     <= left_d;
      rpt_q      <= rpt_d;
      pos_q      <= pos_d;
      gath_q     <= gath_d;
    end
  end

endmodule : tgarle_decode

`default_nettype wire

// ----- rtl/core/tgarle_out_reg.sv -----
// ----------------------------------------------------------------------------
// tgarle_out_reg
// Result register driving the pixel output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_out_reg
  import tgarle_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire pix_t       data_i,
  output logic            free_o,
  tgarle_pix_if.source    pix_o
);

  logic valid_q;
  pix_t data_q;

  // Slot can take a new result when empty or being drained this cycle
  assign free_o = !valid_q || pix_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (pix_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign pix_o.valid        = valid_q;
  assign pix_o.red          = data_q.red;
  assign pix_o.green        = data_q.green;
  assign pix_o.blue         = data_q.blue;
  assign pix_o.pixel_code   = data_q.pixel_code;
  assign pix_o.repeat_count = data_q.repeat_count;

endmodule : tgarle_out_reg

`default_nettype wire

// ----- rtl/core/tga_rle_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Targa pixel-data decoder with optional run-length packets.
//
// byte_i takes one pixel-data byte per transaction; pix_o gives one
// transaction per completed pixel (RGB, raw code word, repeat count).
// A repeat packet yields one pixel carrying the full count.
// Configuration (rle_enable, pixel_format) is written through cfg_we_i /
// cfg_idx_i / cfg_data_i while no byte is in flight.
// Throughput: one byte per cycle while pix_o.ready is high.
// Path: an accepted byte is held in the input register, decoded from there
// and loaded into the result register when the result slot is free; its
// pixel is offered on pix_o straight from the result register.
// Stall: while the result register holds an untaken pixel the input
// register holds its byte; byte_i.ready drops once the input register is
// full and cannot advance.
// Reset: packet state waits for a header, no byte gathered, rle_enable 0,
// pixel_format bgr24, both channels empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder
  import tgarle_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [1:0] cfg_data_i,
  tgarle_byte_if.sink     byte_i,
  tgarle_pix_if.source    pix_o
);

  logic       rle_en_q;
  pix_fmt_e   fmt_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       slot_free;
  logic       advance;
  logic       res_valid;
  pix_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_en_q <= RLE_ENABLE_RST;
      fmt_q    <= PIXEL_FORMAT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RLE_ENABLE:   rle_en_q <= cfg_data_i[0];
        CFG_PIXEL_FORMAT: fmt_q    <= pix_fmt_e'(cfg_data_i);
        default:          rle_en_q <= rle_en_q;
      endcase
    end
  end

  assign advance      = in_valid_q && slot_free;
  assign byte_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
    end
  end

  tgarle_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .rle_en_i    (rle_en_q),
    .fmt_i       (fmt_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tgarle_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance && res_valid),
    .data_i (res),
    .free_o (slot_free),
    .pix_o  (pix_o)
  );

  // A decoded pixel must show up on the output after the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_valid |=> pix_o.valid)
    else $error("decoded pixel not presented on output");

  // Full input register behind a stalled output must backpressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && pix_o.valid && !pix_o.ready |-> !byte_i.ready)
    else $error("input accepted while pipeline stalled");

  // Every pixel stands for at least one image pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_o.valid |-> pix_o.repeat_count != 8'd0)
    else $error("zero repeat count on output");

endmodule : tga_rle_pixel_decoder

`default_nettype wire

// ----- test/tb_tga_rle_pixel_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder
// Drives Targa pixel-data bytes into the decoder under changing format and
// run-length settings, predicts every decoded pixel and checks it on pix_o.
// ----------------------------------------------------------------------------

module tb_tga_rle_pixel_decoder;
  import tgarle_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned BYTE_TARGET = 1350;

  // Byte-level decoder model plus the queue of pixels it has predicted
  class pixel_scoreboard;
    bit          rle_on;
    pix_fmt_e    fmt;
    bit          hdr_wanted;
    logic [7:0]  run_left;
    bit          run_is_repeat;
    logic [1:0]  pos;
    logic [23:0] held;
    pix_t        pending_px[$];
    int          errors;

    function new();
      rle_on        = RLE_ENABLE_RST;
      fmt           = PIXEL_FORMAT_RST;
      hdr_wanted    = 1'b1;
      run_left      = '0;
      run_is_repeat = 1'b0;
      pos           = '0;
      held          = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic idx, logic [1:0] data);
      if (idx == CFG_RLE_ENABLE) rle_on = data[0];
      else fmt = pix_fmt_e'(data);
    endfunction

    function void note_byte(logic [7:0] b);
      pix_t px;
      if (rle_on && hdr_wanted) begin
        run_is_repeat = b[HDR_REPEAT_BIT];
        run_left      = {1'b0, b[6:0]} + 8'd1;
        hdr_wanted    = 1'b0;
        return;
      end
      // a format switch mid-pixel completes as soon as pos reaches the new last byte
      if (pos < 2'(fmt)) begin
        held[8*pos +: 8] = b;
        pos = pos + 2'd1;
        return;
      end
      case (fmt)
        FMT_GREY8: begin
          px.red = b; px.green = b; px.blue = b;
          px.pixel_code = {8'h00, b};
        end
        FMT_RGB555: begin
          px.red        = {3'b000, b[6:2]};
          px.green      = {3'b000, b[1:0], held[7:5]};
          px.blue       = {3'b000, held[4:0]};
          px.pixel_code = {b, held[7:0]};
        end
        FMT_BGR24: begin
          px.blue = held[7:0]; px.green = held[15:8]; px.red = b;
          px.pixel_code = '0;
        end
        default: begin
          px.blue = held[7:0]; px.green = held[15:8]; px.red = held[23:16];
          px.pixel_code = '0;
        end
      endcase
      pos = '0;
      px.repeat_count = 8'd1;
      if (rle_on) begin
        if (run_is_repeat) begin
          px.repeat_count = (run_left != 0) ? run_left : 8'd1;
          run_left   = '0;
          hdr_wanted = 1'b1;
        end else begin
          if (run_left > 0) run_left = run_left - 8'd1;
          if (run_left == 0) hdr_wanted = 1'b1;
        end
      end
      pending_px.push_back(px);
    endfunction

    function void check_pixel(pix_t got);
      pix_t exp_px;
      if (pending_px.size() == 0) begin
        $error("unexpected pixel: red %0d green %0d blue %0d code %0h count %0d",
               got.red, got.green, got.blue, got.pixel_code, got.repeat_count);
        errors++;
        return;
      end
      exp_px = pending_px.pop_front();
      if (got.red != exp_px.red) begin
        $error("red: expected %0d, got %0d", exp_px.red, got.red);
        errors++;
      end
      if (got.green != exp_px.green) begin
        $error("green: expected %0d, got %0d", exp_px.green, got.green);
        errors++;
      end
      if (got.blue != exp_px.blue) begin
        $error("blue: expected %0d, got %0d", exp_px.blue, got.blue);
        errors++;
      end
      if (got.pixel_code != exp_px.pixel_code) begin
        $error("pixel_code: expected %0h, got %0h", exp_px.pixel_code, got.pixel_code);
        errors++;
      end
      if (got.repeat_count != exp_px.repeat_count) begin
        $error("repeat_count: expected %0d, got %0d", exp_px.repeat_count,
               got.repeat_count);
        errors++;
      end
    endfunction

    function int pending();
      return pending_px.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [1:0]  cfg_data;
  bit          steady;
  bit          cur_rle;
  pix_fmt_e    cur_fmt;
  int unsigned bytes_sent;
  int unsigned cycles;

  pixel_scoreboard sb = new();

  tgarle_byte_if byte_if ();
  tgarle_pix_if  pix_if ();

  tga_rle_pixel_decoder i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .byte_i     (byte_if),
    .pix_o      (pix_if)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Pixel sink: random back-pressure outside steady phases, checked on the rising edge
  always @(negedge clk) begin
    if (rst_n) pix_if.ready <= steady || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin
    if (rst_n && pix_if.valid && pix_if.ready)
      sb.check_pixel({pix_if.red, pix_if.green, pix_if.blue, pix_if.pixel_code,
                      pix_if.repeat_count});
  end

  // All driving tasks enter and leave just after a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 25) begin
      byte_if.valid <= 1'b0;
      @(negedge clk);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    do @(posedge clk); while (!byte_if.ready);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Header or gather bytes give no pixel, so allow the pipeline to drain too
  task automatic wait_idle();
    byte_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_config(input bit wr_rle, input bit rle, input bit wr_fmt,
                            input pix_fmt_e fmt);
    logic spare;
    spare = 1'($urandom_range(1));
    wait_idle();
    if (wr_rle) begin
      write_reg(CFG_RLE_ENABLE, {spare, rle});
      cur_rle = rle;
    end
    if (wr_fmt) begin
      write_reg(CFG_PIXEL_FORMAT, fmt);
      cur_fmt = fmt;
    end
    cfg_we <= 1'b0;
  endtask

  // Well-formed packet for the current format with random content
  task automatic send_packet();
    logic [7:0] hdr;
    int         n_bytes;
    hdr[7]   = 1'($urandom_range(1));
    hdr[6:0] = ($urandom_range(99) < 80) ? 7'($urandom_range(15)) :
                                           7'($urandom_range(127));
    send_byte(hdr);
    n_bytes = (int'(cur_fmt) + 1) * (hdr[7] ? 1 : int'(hdr[6:0]) + 1);
    repeat (n_bytes) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned phase;
    int unsigned budget;
    int unsigned start;
    int unsigned sel;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_RLE_ENABLE;
    cfg_data          = '0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    pix_if.ready      = 1'b0;
    steady            = 1'b0;
    cur_rle           = RLE_ENABLE_RST;
    cur_fmt           = PIXEL_FORMAT_RST;
    bytes_sent        = 0;
    cycles            = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: bgr24, coding off
    send_byte(8'h00); send_byte(8'h7F); send_byte(8'hFF);
    set_config(1, 0, 1, FMT_GREY8);
    send_byte(8'h00); send_byte(8'hFF);
    set_config(0, 0, 1, FMT_RGB555);
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h80);
    set_config(0, 0, 1, FMT_BGRA32);
    send_byte(8'h11); send_byte(8'h22); send_byte(8'h33); send_byte(8'h44);
    // two bytes into a 32-bit pixel, then drop to 16-bit: next byte completes it
    send_byte(8'hAA); send_byte(8'hBB);
    set_config(0, 0, 1, FMT_RGB555);
    send_byte(8'hC3);
    // coding turned on with one byte gathered: header first, then resume
    set_config(0, 0, 1, FMT_BGR24);
    send_byte(8'h01);
    set_config(1, 1, 0, FMT_BGR24);
    send_byte(8'hFF); send_byte(8'h02); send_byte(8'h03);
    set_config(0, 1, 1, FMT_GREY8);
    send_byte(8'h00); send_byte(8'h5A);
    send_byte(8'h81); send_byte(8'hA5);

    phase = 0;
    while (bytes_sent < BYTE_TARGET) begin
      sel = $urandom_range(3);
      set_config(sel != 1, $urandom_range(2) != 0, sel != 0,
                 pix_fmt_e'($urandom_range(3)));
      steady = (phase >= 4 && phase < 8);
      budget = $urandom_range(20, 120);
      start  = bytes_sent;
      if (cur_rle) begin
        while (bytes_sent - start < budget) begin
          // stray bytes knock the packet framing out of step
          if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3))
            send_byte(8'($urandom_range(255)));
          else send_packet();
        end
      end else begin
        repeat (budget) send_byte(8'($urandom_range(255)));
      end
      phase++;
    end
    steady = 1'b0;

    byte_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tgarle_pkg.sv
rtl/core/tgarle_byte_if.sv
rtl/core/tgarle_pix_if.sv
rtl/core/tgarle_decode.sv
rtl/core/tgarle_out_reg.sv
rtl/core/tga_rle_pixel_decoder.sv
test/tb_tga_rle_pixel_decoder.sv
